>>> rtl/core/tth_pkg.sv
// ----------------------------------------------------------------------------
// tth_pkg - shared types and constants of the telnet terminal byte handler
// Telnet command codes, option codes and the job descriptor that the front
// parser hands to the back expander.
// ----------------------------------------------------------------------------
`default_nettype none

package tth_pkg;

  // Telnet command bytes
  localparam logic [7:0] TEL_SE   = 8'd240;
  localparam logic [7:0] TEL_SB   = 8'd250;
  localparam logic [7:0] TEL_WILL = 8'd251;
  localparam logic [7:0] TEL_WONT = 8'd252;
  localparam logic [7:0] TEL_DO   = 8'd253;
  localparam logic [7:0] TEL_DONT = 8'd254;
  localparam logic [7:0] TEL_IAC  = 8'd255;

  // Option codes and control characters
  localparam logic [7:0] OPT_REMOTE_ECHO = 8'd1;
  localparam logic [7:0] OPT_SGA  = 8'd3;
  localparam logic [7:0] OPT_NAWS = 8'd31;
  localparam logic [7:0] CHR_ESC  = 8'h1B;
  localparam logic [7:0] CHR_CR   = 8'd13;
  localparam logic [7:0] CHR_LF   = 8'd10;
  localparam logic [7:0] CHR_ETX  = 8'd3;

  // Local command keys
  localparam logic [7:0] CMD_QUIT      = 8'd113;  // q
  localparam logic [7:0] CMD_ECHO      = 8'd101;  // e
  localparam logic [7:0] CMD_CRLF      = 8'd110;  // n
  localparam logic [7:0] CMD_NEGOTIATE = 8'd116;  // t
  localparam logic [7:0] CMD_BREAK     = 8'd99;   // c
  localparam logic [7:0] CMD_ESCAPE    = 8'd93;   // ]

  // ANSI escape sequence characters
  localparam logic [7:0] ANSI_SEP = 8'd59;   // ;
  localparam logic [7:0] ANSI_CUP = 8'd72;   // H
  localparam logic [7:0] ANSI_HVP = 8'd102;  // f

  // Result destinations
  localparam logic [1:0] DEST_DISPLAY = 2'd0;
  localparam logic [1:0] DEST_CURSOR  = 2'd1;
  localparam logic [1:0] DEST_SEND    = 2'd2;
  localparam logic [1:0] DEST_QUIT    = 2'd3;

  // Configuration register indexes and reset values
  localparam logic       REG_COLS = 1'b0;
  localparam logic       REG_ROWS = 1'b1;
  localparam logic [7:0] COLS_RST = 8'd40;
  localparam logic [7:0] ROWS_RST = 8'd30;

  // Queue depth
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  typedef enum logic [2:0] {
    JOB_DISPLAY,   // one display character
    JOB_CURSOR,    // one cursor move
    JOB_QUIT,      // quit request
    JOB_SEND,      // one transmitted byte
    JOB_KEY,       // optional echo, then byte or CR LF
    JOB_NAWS,      // nine-byte window size reply
    JOB_ECHO_REP,  // IAC DO/DONT ECHO
    JOB_SGA        // IAC DO SGA IAC WILL NAWS
  } job_kind_e;

  typedef struct packed {
    job_kind_e  kind;
    logic [7:0] data;
    logic [7:0] col;
    logic [7:0] row;
    logic       echo;  // local echo setting carried by every result
    logic       show;  // key job: echo the key to the display first
    logic       crlf;  // key job: send CR LF in place of the byte
  } job_t;

endpackage

`default_nettype wire

>>> rtl/core/tth_front.sv
// ----------------------------------------------------------------------------
// tth_front - byte parser
// Runs the telnet, escape and keyboard parsers on each accepted byte, updates
// the terminal state and emits at most one job describing the results.
// ----------------------------------------------------------------------------
`default_nettype none

module tth_front (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  input  wire              in_kind_i,
  input  wire        [7:0] in_byte_i,
  output tth_pkg::job_t    job_o,
  output logic             job_valid_o
);

  typedef enum logic [2:0] {
    PC_NONE, PC_SB, PC_WILL, PC_WONT, PC_DO, PC_DONT
  } pend_e;

  pend_e      pend_q, pend_d;
  logic       echo_q, echo_d;
  logic       nlx_q, nlx_d;
  logic       cmd_q, cmd_d;
  logic       iac_q, iac_d;
  logic       esc_q, esc_d;
  logic [1:0] esc_cnt_q, esc_cnt_d;
  logic [1:0] pidx_q, pidx_d;
  logic [7:0] prow_q, prow_d;
  logic [7:0] pcol_q, pcol_d;
  logic       ddone_q, ddone_d;

  logic [7:0] c;
  logic       letter;
  logic       digit;
  logic [7:0] dval;
  logic [7:0] row_m1;
  logic [7:0] col_m1;

  assign c      = in_byte_i;
  assign letter = ((c >= 8'd97) && (c <= 8'd122)) || ((c >= 8'd65) && (c <= 8'd90));
  assign digit  = (c >= 8'd48) && (c <= 8'd57);
  assign dval   = c - 8'd48;
  assign row_m1 = (prow_q == 8'd0) ? 8'd0 : prow_q - 8'd1;
  assign col_m1 = (pcol_q == 8'd0) ? 8'd0 : pcol_q - 8'd1;

  // Parse one byte and build its job
  always_comb begin
    pend_d      = pend_q;
    echo_d      = echo_q;
    nlx_d       = nlx_q;
    cmd_d       = cmd_q;
    iac_d       = iac_q;
    esc_d       = esc_q;
    esc_cnt_d   = esc_cnt_q;
    pidx_d      = pidx_q;
    prow_d      = prow_q;
    pcol_d      = pcol_q;
    ddone_d     = ddone_q;
    job_valid_o = 1'b0;
    job_o.kind  = tth_pkg::JOB_DISPLAY;
    job_o.data  = c;
    job_o.col   = 8'd0;
    job_o.row   = 8'd0;
    job_o.show  = 1'b0;
    job_o.crlf  = 1'b0;

    if (in_valid_i) begin
      if (in_kind_i) begin
        // Keyboard byte
        if (c == tth_pkg::CHR_ESC) begin
          cmd_d = ~cmd_q;
        end else if (c == 8'd0) begin
          cmd_d = cmd_q;
        end else if (cmd_q) begin
          cmd_d = 1'b0;
          case (c)
            tth_pkg::CMD_QUIT: begin
              job_valid_o = 1'b1;
              job_o.kind  = tth_pkg::JOB_QUIT;
            end
            tth_pkg::CMD_ECHO: echo_d = ~echo_q;
            tth_pkg::CMD_CRLF: nlx_d = ~nlx_q;
            tth_pkg::CMD_NEGOTIATE: begin
              job_valid_o = 1'b1;
              job_o.kind  = tth_pkg::JOB_SGA;
            end
            tth_pkg::CMD_BREAK: begin
              job_valid_o = 1'b1;
              job_o.kind  = tth_pkg::JOB_SEND;
              job_o.data  = tth_pkg::CHR_ETX;
            end
            tth_pkg::CMD_ESCAPE: begin
              job_valid_o = 1'b1;
              job_o.kind  = tth_pkg::JOB_SEND;
              job_o.data  = tth_pkg::CHR_ESC;
            end
            default: cmd_d = 1'b0;
          endcase
        end else begin
          job_valid_o = 1'b1;
          job_o.kind  = tth_pkg::JOB_KEY;
          job_o.show  = echo_q;
          job_o.crlf  = (c == tth_pkg::CHR_LF) && nlx_q;
        end
      end else if (iac_q) begin
        // Byte after IAC
        iac_d = 1'b0;
        if (pend_q == PC_SB) begin
          if (c == tth_pkg::TEL_SE) pend_d = PC_NONE;
        end else if (c == tth_pkg::TEL_IAC) begin
          job_valid_o = 1'b1;
          job_o.kind  = tth_pkg::JOB_DISPLAY;
        end else if (c == tth_pkg::TEL_SB) begin
          pend_d = PC_SB;
        end else if (c == tth_pkg::TEL_WILL) begin
          pend_d = PC_WILL;
        end else if (c == tth_pkg::TEL_WONT) begin
          pend_d = PC_WONT;
        end else if (c == tth_pkg::TEL_DO) begin
          pend_d = PC_DO;
        end else if (c == tth_pkg::TEL_DONT) begin
          pend_d = PC_DONT;
        end
      end else if (pend_q == PC_SB) begin
        // Discard subnegotiation, watch for IAC
        if (c == tth_pkg::TEL_IAC) iac_d = 1'b1;
      end else if (pend_q != PC_NONE) begin
        // Option byte of WILL/WONT/DO/DONT
        pend_d = PC_NONE;
        if ((pend_q == PC_DO) && (c == tth_pkg::OPT_NAWS)) begin
          job_valid_o = 1'b1;
          job_o.kind  = tth_pkg::JOB_NAWS;
        end
        if (((pend_q == PC_WILL) || (pend_q == PC_WONT)) &&
            (c == tth_pkg::OPT_REMOTE_ECHO)) begin
          echo_d      = (pend_q == PC_WONT);
          job_valid_o = 1'b1;
          job_o.kind  = tth_pkg::JOB_ECHO_REP;
          job_o.data  = (pend_q == PC_WILL) ? tth_pkg::TEL_DO : tth_pkg::TEL_DONT;
        end
      end else if (c == tth_pkg::TEL_IAC) begin
        iac_d = 1'b1;
      end else if (c == tth_pkg::CHR_ESC) begin
        // Start or restart an escape sequence
        esc_d     = 1'b1;
        esc_cnt_d = 2'd0;
        pidx_d    = 2'd0;
        prow_d    = 8'd0;
        pcol_d    = 8'd0;
        ddone_d   = 1'b0;
      end else if (esc_q) begin
        if (letter) begin
          if ((c == tth_pkg::ANSI_CUP) || (c == tth_pkg::ANSI_HVP)) begin
            job_valid_o = 1'b1;
            job_o.kind  = tth_pkg::JOB_CURSOR;
            job_o.col   = col_m1;
            job_o.row   = row_m1;
          end
          esc_d = 1'b0;
        end else if (esc_cnt_q == 2'd0) begin
          esc_cnt_d = 2'd1;
        end else begin
          esc_cnt_d = 2'd2;
          if (c == tth_pkg::ANSI_SEP) begin
            if (pidx_q < 2'd2) pidx_d = pidx_q + 2'd1;
            ddone_d = 1'b0;
          end else if (digit) begin
            if (!ddone_q && (pidx_q == 2'd0)) prow_d = 8'(prow_q * 8'd10) + dval;
            if (!ddone_q && (pidx_q == 2'd1)) pcol_d = 8'(pcol_q * 8'd10) + dval;
          end else begin
            ddone_d = 1'b1;
          end
        end
      end else if (c != 8'd0) begin
        job_valid_o = 1'b1;
        job_o.kind  = tth_pkg::JOB_DISPLAY;
      end
    end
    job_o.echo = echo_d;
  end

  // Hold parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= PC_NONE;
      echo_q    <= 1'b1;
      nlx_q     <= 1'b1;
      cmd_q     <= 1'b0;
      iac_q     <= 1'b0;
      esc_q     <= 1'b0;
      esc_cnt_q <= 2'd0;
      pidx_q    <= 2'd0;
      prow_q    <= 8'd0;
      pcol_q    <= 8'd0;
      ddone_q   <= 1'b0;
    end else begin
      pend_q    <= pend_d;
      echo_q    <= echo_d;
      nlx_q     <= nlx_d;
      cmd_q     <= cmd_d;
      iac_q     <= iac_d;
      esc_q     <= esc_d;
      esc_cnt_q <= esc_cnt_d;
      pidx_q    <= pidx_d;
      prow_q    <= prow_d;
      pcol_q    <= pcol_d;
      ddone_q   <= ddone_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/tth_queue.sv
// ----------------------------------------------------------------------------
// tth_queue - job queue
// Small first-in first-out queue of jobs between the parser and the expander.
// ----------------------------------------------------------------------------
`default_nettype none

module tth_queue (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  tth_pkg::job_t    push_job_i,
  output logic             full_o,
  input  wire              pop_i,
  output tth_pkg::job_t    head_o,
  output logic             valid_o
);

  tth_pkg::job_t               mem_q [tth_pkg::QDEPTH];
  logic [tth_pkg::QAW-1:0]     wptr_q, rptr_q;
  logic [tth_pkg::QAW:0]       cnt_q;
  logic                        do_push, do_pop;

  assign full_o  = (cnt_q == (tth_pkg::QAW+1)'(tth_pkg::QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Store pushed jobs
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= push_job_i;
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= wptr_q + 1'b1;
      if (do_pop) rptr_q <= rptr_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/tth_back.sv
// ----------------------------------------------------------------------------
// tth_back - result expander
// Steps through the result items of the job at the queue head into a
// registered output stage, one item per cycle while that stage is empty or taken.
// ----------------------------------------------------------------------------
`default_nettype none

module tth_back (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  tth_pkg::job_t    job_i,
  input  wire              job_valid_i,
  output logic             job_pop_o,
  input  wire        [7:0] cols_i,
  input  wire        [7:0] rows_i,
  output logic             out_valid_o,
  input  wire              out_ready_i,
  output logic       [1:0] out_dest_o,
  output logic       [7:0] out_byte_o,
  output logic       [7:0] out_col_o,
  output logic       [7:0] out_row_o,
  output logic             out_echo_o,
  output logic             out_last_o
);

  logic [3:0] step_q;
  logic [3:0] tstep;
  logic [1:0] dest;
  logic [7:0] obyte;
  logic [3:0] len;
  logic       last;
  logic       load;

  assign tstep = step_q - {3'd0, job_i.show};

  // Select the item at the current step
  always_comb begin
    dest  = tth_pkg::DEST_SEND;
    obyte = 8'd0;
    len   = 4'd1;
    case (job_i.kind)
      tth_pkg::JOB_DISPLAY: begin
        dest  = tth_pkg::DEST_DISPLAY;
        obyte = job_i.data;
      end
      tth_pkg::JOB_CURSOR: dest = tth_pkg::DEST_CURSOR;
      tth_pkg::JOB_QUIT:   dest = tth_pkg::DEST_QUIT;
      tth_pkg::JOB_SEND:   obyte = job_i.data;
      tth_pkg::JOB_KEY: begin
        len = {3'd0, job_i.show} + (job_i.crlf ? 4'd2 : 4'd1);
        if (job_i.show && (step_q == 4'd0)) begin
          dest  = tth_pkg::DEST_DISPLAY;
          obyte = job_i.data;
        end else if (job_i.crlf) begin
          obyte = (tstep == 4'd0) ? tth_pkg::CHR_CR : tth_pkg::CHR_LF;
        end else begin
          obyte = job_i.data;
        end
      end
      tth_pkg::JOB_NAWS: begin
        len = 4'd9;
        case (step_q)
          4'd0:    obyte = tth_pkg::TEL_IAC;
          4'd1:    obyte = tth_pkg::TEL_SB;
          4'd2:    obyte = tth_pkg::OPT_NAWS;
          4'd4:    obyte = cols_i;
          4'd6:    obyte = rows_i;
          4'd7:    obyte = tth_pkg::TEL_IAC;
          4'd8:    obyte = tth_pkg::TEL_SE;
          default: obyte = 8'd0;
        endcase
      end
      tth_pkg::JOB_ECHO_REP: begin
        len = 4'd3;
        case (step_q)
          4'd0:    obyte = tth_pkg::TEL_IAC;
          4'd1:    obyte = job_i.data;
          default: obyte = tth_pkg::OPT_REMOTE_ECHO;
        endcase
      end
      tth_pkg::JOB_SGA: begin
        len = 4'd6;
        case (step_q)
          4'd0:    obyte = tth_pkg::TEL_IAC;
          4'd1:    obyte = tth_pkg::TEL_DO;
          4'd2:    obyte = tth_pkg::OPT_SGA;
          4'd3:    obyte = tth_pkg::TEL_IAC;
          4'd4:    obyte = tth_pkg::TEL_WILL;
          default: obyte = tth_pkg::OPT_NAWS;
        endcase
      end
      default: dest = tth_pkg::DEST_SEND;
    endcase
  end

  assign last      = (step_q == len - 4'd1);
  assign load      = job_valid_i && (!out_valid_o || out_ready_i);
  assign job_pop_o = load && last;

  // Advance the step within the job
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= 4'd0;
      out_valid_o <= 1'b0;
    end else begin
      if (load) step_q <= last ? 4'd0 : step_q + 4'd1;
      if (load) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
    end
  end

  // Hold the output item until taken
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_dest_o <= dest;
      out_byte_o <= obyte;
      out_col_o  <= (job_i.kind == tth_pkg::JOB_CURSOR) ? job_i.col : 8'd0;
      out_row_o  <= (job_i.kind == tth_pkg::JOB_CURSOR) ? job_i.row : 8'd0;
      out_echo_o <= job_i.echo;
      out_last_o <= last;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/telnet_terminal_byte_handler.sv
// ----------------------------------------------------------------------------
// telnet_terminal_byte_handler - telnet terminal byte handler, top level
// Parses network and keyboard bytes and produces display, cursor, transmit
// and quit results.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle on the slave stream (tuser 0 network,
// 1 keyboard) as long as its four-entry job queue has room. Each byte yields
// zero to nine results on the master stream, one per cycle while tready is
// high; a byte's last result carries tlast. Sustained throughput is set by
// the result expander. Window size for the NAWS reply is read from two APB
// registers (columns at 0x0, rows at 0x4) that must only be written while
// the block is idle.
`default_nettype none

module telnet_terminal_byte_handler (
  input  wire         clk_i,
  input  wire         rst_ni,
  // Input stream
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire   [7:0] s_axis_tdata,   // [7:0] data_byte
  input  wire         s_axis_tuser,   // [0] kind
  // Output stream
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] out_byte, [15:8] cursor_col,
                                      // [23:16] cursor_row, [24] echo_on
  output logic  [1:0] m_axis_tuser,   // [1:0] destination
  output logic        m_axis_tlast,
  // APB configuration
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire   [2:0] paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]    cols_q, rows_q;
  tth_pkg::job_t fr_job, q_head;
  logic          fr_valid, q_full, q_valid, q_pop;
  logic          in_acc, cfg_wr;
  logic [7:0]    out_byte, out_col, out_row;
  logic          out_echo;

  assign s_axis_tready = !q_full;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = {24'd0, (paddr[2] == tth_pkg::REG_ROWS) ? rows_q : cols_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= tth_pkg::COLS_RST;
      rows_q <= tth_pkg::ROWS_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == tth_pkg::REG_COLS) cols_q <= pwdata[7:0];
      else rows_q <= pwdata[7:0];
    end
  end

  tth_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_acc),
    .in_kind_i   (s_axis_tuser),
    .in_byte_i   (s_axis_tdata),
    .job_o       (fr_job),
    .job_valid_o (fr_valid)
  );

  tth_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (fr_valid),
    .push_job_i (fr_job),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .head_o     (q_head),
    .valid_o    (q_valid)
  );

  tth_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (q_head),
    .job_valid_i (q_valid),
    .job_pop_o   (q_pop),
    .cols_i      (cols_q),
    .rows_i      (rows_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_dest_o  (m_axis_tuser),
    .out_byte_o  (out_byte),
    .out_col_o   (out_col),
    .out_row_o   (out_row),
    .out_echo_o  (out_echo),
    .out_last_o  (m_axis_tlast)
  );

  // Pack the result fields
  assign m_axis_tdata = {7'd0, out_echo, out_row, out_col, out_byte};

endmodule

`default_nettype wire
